// ----- hw/rtl/ca_dss_pkg.sv -----
`default_nettype none

package ca_dss_pkg;

   // Field widths.
   localparam int COORD_BITS = 22;
   localparam int DIFF_BITS  = 20;
   localparam int SQ_BITS    = 2 * DIFF_BITS;
   localparam int D2_BITS    = SQ_BITS + 2;
   localparam int P_BITS     = 3;
   localparam int CNT_BITS   = 2;
   localparam int NUM_LAGS   = 3;
   localparam int NUM_AXES   = 3;

   // Residue counter saturates once the window is full.
   localparam logic [P_BITS-1:0] P_FULL = 3'd4;

   typedef logic [1:0] ss_code_type;

   localparam ss_code_type SS_LOOP   = 2'd0;
   localparam ss_code_type SS_HELIX  = 2'd1;
   localparam ss_code_type SS_STRAND = 2'd2;
   localparam ss_code_type SS_TURN   = 2'd3;

   typedef logic [NUM_LAGS-1:0][NUM_AXES-1:0][SQ_BITS-1:0] sq_set_type;

   // Control word that travels with the squares.
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [P_BITS-1:0] p;
   } sq_ctl_type;

   // Results caused by one item: a head code followed by loop codes.
   typedef struct packed {
      logic [CNT_BITS-1:0] cnt;
      ss_code_type         head;
      logic                last;
   } res_type;

   // Band bounds on the squared distance in 1/65536 square angstrom.
   // A band lo < d < hi in hundredths of an angstrom becomes
   // D2 > floor(lo^2 * 65536 / 10000) and D2 < ceil(hi^2 * 65536 / 10000).
   // Index 0 is the distance two residues apart, 1 three apart, 2 four apart.
   localparam logic [NUM_LAGS-1:0][D2_BITS-1:0] HELIX_LO = {
      D2_BITS'(64'd427 * 64'd427 * 64'd65536 / 64'd10000),
      D2_BITS'(64'd308 * 64'd308 * 64'd65536 / 64'd10000),
      D2_BITS'(64'd335 * 64'd335 * 64'd65536 / 64'd10000)
   };
   localparam logic [NUM_LAGS-1:0][D2_BITS-1:0] HELIX_HI = {
      D2_BITS'((64'd847 * 64'd847 * 64'd65536 + 64'd9999) / 64'd10000),
      D2_BITS'((64'd728 * 64'd728 * 64'd65536 + 64'd9999) / 64'd10000),
      D2_BITS'((64'd755 * 64'd755 * 64'd65536 + 64'd9999) / 64'd10000)
   };
   localparam logic [NUM_LAGS-1:0][D2_BITS-1:0] STRAND_LO = {
      D2_BITS'(64'd1158 * 64'd1158 * 64'd65536 / 64'd10000),
      D2_BITS'(64'd898 * 64'd898 * 64'd65536 / 64'd10000),
      D2_BITS'(64'd468 * 64'd468 * 64'd65536 / 64'd10000)
   };
   localparam logic [NUM_LAGS-1:0][D2_BITS-1:0] STRAND_HI = {
      D2_BITS'((64'd1442 * 64'd1442 * 64'd65536 + 64'd9999) / 64'd10000),
      D2_BITS'((64'd1182 * 64'd1182 * 64'd65536 + 64'd9999) / 64'd10000),
      D2_BITS'((64'd752 * 64'd752 * 64'd65536 + 64'd9999) / 64'd10000)
   };
   localparam logic [D2_BITS-1:0] TURN_HI =
      D2_BITS'((64'd800 * 64'd800 * 64'd65536 + 64'd9999) / 64'd10000);

endpackage

`default_nettype wire

// ----- hw/rtl/ca_dss_if.sv -----
`default_nettype none

// Residue word channel.
interface ca_dss_req_if #(
   parameter int COORD_BITS = ca_dss_pkg::COORD_BITS
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic signed [COORD_BITS-1:0] coord_z;
   logic                         chain_last;

   modport source (output valid, coord_x, coord_y, coord_z, chain_last, input ready);
   modport sink (input valid, coord_x, coord_y, coord_z, chain_last, output ready);
endinterface

// Classification word channel.
interface ca_dss_rsp_if;
   logic                    valid;
   logic                    ready;
   ca_dss_pkg::ss_code_type ss_code;
   logic                    run_last;
   logic                    chain_end;

   modport source (output valid, ss_code, run_last, chain_end, input ready);
   modport sink (input valid, ss_code, run_last, chain_end, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ca_dss_front.sv -----
`default_nettype none

module ca_dss_front #(
   parameter int COORD_BITS = ca_dss_pkg::COORD_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   output      logic                               in_ready,
   input  wire logic signed [COORD_BITS-1:0]       in_x,
   input  wire logic signed [COORD_BITS-1:0]       in_y,
   input  wire logic signed [COORD_BITS-1:0]       in_z,
   input  wire logic                               in_last,
   input  wire logic                               sq_go,
   output      ca_dss_pkg::sq_ctl_type             sq_ctl,
   output      ca_dss_pkg::sq_set_type             sq_set
);

   localparam int DB       = ca_dss_pkg::DIFF_BITS;
   localparam int ABS_BITS = (COORD_BITS + 1 > DB) ? COORD_BITS + 1 : DB + 1;
   localparam int NA       = ca_dss_pkg::NUM_AXES;
   localparam int NL       = ca_dss_pkg::NUM_LAGS;

   // Absolute difference, clamped to the widest value the squarers take.
   function automatic logic [DB-1:0] clamp_abs(input logic signed [COORD_BITS-1:0] a,
                                               input logic signed [COORD_BITS-1:0] b);
      logic signed [COORD_BITS:0] diff;
      logic [ABS_BITS-1:0]        mag;
      diff = (COORD_BITS + 1)'(a) - (COORD_BITS + 1)'(b);
      mag  = ABS_BITS'($unsigned(diff[COORD_BITS] ? -diff : diff));
      return (|mag[ABS_BITS-1:DB]) ? {DB{1'b1}} : mag[DB-1:0];
   endfunction

   logic [ca_dss_pkg::P_BITS-1:0]  p_ff, p_in;
   logic                           in_valid_ff;
   logic                           in_last_ff;
   logic [ca_dss_pkg::P_BITS-1:0]  in_p_ff;
   logic signed [COORD_BITS-1:0]   in_c_ff [NA];
   logic signed [COORD_BITS-1:0]   win_ff [NA][4];
   ca_dss_pkg::sq_ctl_type         sq_ctl_ff;
   ca_dss_pkg::sq_set_type         sq_set_ff, sq_set_in;
   logic                           accept;
   logic                           in_go;
   logic                           sq_free;
   logic [DB-1:0]                  mag;

   assign sq_free  = !sq_ctl_ff.valid || sq_go;
   assign in_go    = in_valid_ff && sq_free;
   assign in_ready = !in_valid_ff || in_go;
   assign accept   = in_valid && in_ready;

   // Residues seen in the current chain, counted in acceptance order.
   always_comb begin
      if (in_last) begin
         p_in = '0;
      end else if (p_ff < ca_dss_pkg::P_FULL) begin
         p_in = p_ff + 1'b1;
      end else begin
         p_in = ca_dss_pkg::P_FULL;
      end
   end

   // Input register and its control.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff        <= '0;
         in_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            p_ff <= p_in;
         end
         if (in_ready) begin
            in_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_c_ff[0] <= in_x;
         in_c_ff[1] <= in_y;
         in_c_ff[2] <= in_z;
         in_last_ff <= in_last;
         in_p_ff    <= p_ff;
      end
   end

   // Four previous positions, oldest in entry 0.
   always_ff @(posedge clock) begin
      if (in_go) begin
         for (int a = 0; a < NA; a++) begin
            win_ff[a][0] <= win_ff[a][1];
            win_ff[a][1] <= win_ff[a][2];
            win_ff[a][2] <= win_ff[a][3];
            win_ff[a][3] <= in_c_ff[a];
         end
      end
   end

   // Squared axis distances from the new residue back two, three and four places.
   always_comb begin
      sq_set_in = '0;
      mag       = '0;
      for (int l = 0; l < NL; l++) begin
         for (int a = 0; a < NA; a++) begin
            mag = clamp_abs(in_c_ff[a], win_ff[a][NL - 1 - l]);
            sq_set_in[l][a] = ca_dss_pkg::SQ_BITS'(mag) * ca_dss_pkg::SQ_BITS'(mag);
         end
      end
   end

   // Square stage: the valid flag is reset, the payload loads on each move.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ctl_ff.valid <= 1'b0;
      end else if (sq_free) begin
         sq_ctl_ff.valid <= in_valid_ff;
      end
      if (in_go) begin
         sq_ctl_ff.last <= in_last_ff;
         sq_ctl_ff.p    <= in_p_ff;
         sq_set_ff      <= sq_set_in;
      end
   end

   assign sq_ctl = sq_ctl_ff;
   assign sq_set = sq_set_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ca_dss_class.sv -----
`default_nettype none

module ca_dss_class (
   input  wire logic                   clock,
   input  wire ca_dss_pkg::sq_ctl_type sq_ctl,
   input  wire ca_dss_pkg::sq_set_type sq_set,
   input  wire logic                   sq_go,
   output      ca_dss_pkg::res_type    res
);

   localparam int NL = ca_dss_pkg::NUM_LAGS;

   logic [ca_dss_pkg::D2_BITS-1:0] d2 [NL];
   logic [NL-1:0]                  helix_band;
   logic [NL-1:0]                  strand_band;
   // Band flags of earlier items: two places apart from one and two items
   // back, three places apart from one item back.
   logic                           h2_p1_ff, h2_p2_ff, h3_p1_ff;
   logic                           s2_p1_ff, s2_p2_ff, s3_p1_ff;
   logic                           is_helix, is_strand, is_turn;
   ca_dss_pkg::ss_code_type        code;

   // Squared distances and their band tests.
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         d2[l] = ca_dss_pkg::D2_BITS'(sq_set[l][0]) + ca_dss_pkg::D2_BITS'(sq_set[l][1])
               + ca_dss_pkg::D2_BITS'(sq_set[l][2]);
         helix_band[l]  = d2[l] > ca_dss_pkg::HELIX_LO[l] && d2[l] < ca_dss_pkg::HELIX_HI[l];
         strand_band[l] = d2[l] > ca_dss_pkg::STRAND_LO[l] && d2[l] < ca_dss_pkg::STRAND_HI[l];
      end
   end

   // Each older distance in the window was new for an earlier item.
   always_ff @(posedge clock) begin
      if (sq_go) begin
         h2_p2_ff <= h2_p1_ff;
         h2_p1_ff <= helix_band[0];
         h3_p1_ff <= helix_band[1];
         s2_p2_ff <= s2_p1_ff;
         s2_p1_ff <= strand_band[0];
         s3_p1_ff <= strand_band[1];
      end
   end

   assign is_helix  = &helix_band && h2_p1_ff && h2_p2_ff && h3_p1_ff;
   assign is_strand = &strand_band && s2_p1_ff && s2_p2_ff && s3_p1_ff;
   assign is_turn   = d2[NL-1] < ca_dss_pkg::TURN_HI;

   always_comb begin
      if (is_helix) begin
         code = ca_dss_pkg::SS_HELIX;
      end else if (is_strand) begin
         code = ca_dss_pkg::SS_STRAND;
      end else if (is_turn) begin
         code = ca_dss_pkg::SS_TURN;
      end else begin
         code = ca_dss_pkg::SS_LOOP;
      end
   end

   // Results caused by this item; any after the head are loop.
   always_comb begin
      res.last = sq_ctl.last;
      res.head = ca_dss_pkg::SS_LOOP;
      case (sq_ctl.p) inside
         3'd0, 3'd1: begin
            res.cnt = 2'd1;
         end
         3'd2: begin
            res.cnt = sq_ctl.last ? 2'd1 : 2'd0;
         end
         3'd3: begin
            res.cnt = sq_ctl.last ? 2'd2 : 2'd0;
         end
         default: begin
            res.head = code;
            res.cnt  = sq_ctl.last ? 2'd3 : 2'd1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ca_dss_out.sv -----
`default_nettype none

module ca_dss_out (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ca_dss_pkg::res_type     res,
   input  wire logic                    load,
   output      logic                    load_ok,
   output      logic                    out_valid,
   input  wire logic                    out_ready,
   output      ca_dss_pkg::ss_code_type out_code,
   output      logic                    out_run_last,
   output      logic                    out_chain_end
);

   logic [ca_dss_pkg::CNT_BITS-1:0] cnt_ff;
   ca_dss_pkg::ss_code_type         head_ff;
   logic                            last_ff;
   logic                            pop;

   assign pop     = out_valid && out_ready;
   assign load_ok = cnt_ff == '0 || (cnt_ff == 2'd1 && out_ready);

   // Pending results of one item, handed out one word per cycle while the receiver is ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= res.cnt;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         head_ff <= res.head;
         last_ff <= res.last;
      end else if (pop) begin
         head_ff <= ca_dss_pkg::SS_LOOP;
      end
   end

   assign out_valid     = cnt_ff != '0;
   assign out_code      = head_ff;
   assign out_run_last  = cnt_ff == 2'd1;
   assign out_chain_end = cnt_ff == 2'd1 && last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ca_distance_ss_classifier.sv -----
`default_nettype none

// Alpha-carbon distance secondary-structure classifier. Each input word is one
// residue's position in 1/256 angstrom; each output word is a code (loop, helix,
// strand, turn) for one residue. The first two residues of a chain come out as
// loop at once, later ones two words late, and the word flagged chain_last also
// flushes the last two residues as loop. The block takes one word per cycle
// unless the output holds it back: an input register, a stage of nine 20 by 20
// bit squarers, then sums, band compares and the result register. Results
// come out once their word has passed the input, square and result registers.
// The result register hands out one word per cycle while the receiver is ready,
// so a chain end with a full window yields three results and stalls the input.
module ca_distance_ss_classifier #(
   parameter int COORD_BITS = ca_dss_pkg::COORD_BITS
) (
   input wire logic     clock,
   input wire logic     reset,
   ca_dss_req_if.sink   req_chan,
   ca_dss_rsp_if.source rsp_chan
);

   ca_dss_pkg::sq_ctl_type sq_ctl;
   ca_dss_pkg::sq_set_type sq_set;
   ca_dss_pkg::res_type    res;
   logic                   sq_go;
   logic                   load_ok;
   logic                   load;

   // An item with no results moves on at once; others wait for the result register.
   assign sq_go = sq_ctl.valid && (res.cnt == '0 || load_ok);
   assign load  = sq_go && res.cnt != '0;

   ca_dss_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_chan.valid),
      .in_ready(req_chan.ready),
      .in_x    (req_chan.coord_x),
      .in_y    (req_chan.coord_y),
      .in_z    (req_chan.coord_z),
      .in_last (req_chan.chain_last),
      .sq_go   (sq_go),
      .sq_ctl  (sq_ctl),
      .sq_set  (sq_set)
   );

   ca_dss_class u_class (
      .clock (clock),
      .sq_ctl(sq_ctl),
      .sq_set(sq_set),
      .sq_go (sq_go),
      .res   (res)
   );

   ca_dss_out u_out (
      .clock        (clock),
      .reset        (reset),
      .res          (res),
      .load         (load),
      .load_ok      (load_ok),
      .out_valid    (rsp_chan.valid),
      .out_ready    (rsp_chan.ready),
      .out_code     (rsp_chan.ss_code),
      .out_run_last (rsp_chan.run_last),
      .out_chain_end(rsp_chan.chain_end)
   );

endmodule

`default_nettype wire

// ----- bench/ca_distance_ss_classifier_tb.sv -----
`timescale 1ns / 100ps

module ca_distance_ss_classifier_tb;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_SHOWN     = 10;
   localparam int C_MIN         = -(1 << (ca_dss_pkg::COORD_BITS - 1));
   localparam int C_MAX         = (1 << (ca_dss_pkg::COORD_BITS - 1)) - 1;
   localparam longint GAP_CLAMP = (64'd1 << ca_dss_pkg::DIFF_BITS) - 1;
   localparam real PI           = 3.14159265358979;

   typedef logic signed [ca_dss_pkg::COORD_BITS-1:0] coord_type;

   typedef struct {
      ca_dss_pkg::ss_code_type code;
      logic                    run_last;
      logic                    chain_end;
   } ss_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ca_dss_req_if req_bus ();
   ca_dss_rsp_if rsp_bus ();

   ca_distance_ss_classifier u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Shadow copy of the residue window and chain position.
   coord_type   win_x [4];
   coord_type   win_y [4];
   coord_type   win_z [4];
   int unsigned residues_in_chain;

   ss_word_type expected_codes [$];
   int          idle_pct;
   int          stall_pct;
   int          mismatches;
   int          residues_sent;
   int          chains_sent;
   int          code_count [4];
   int unsigned cycles;

   // Free-running clock, 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Absolute coordinate difference, clamped before squaring.
   function automatic longint unsigned axis_gap(coord_type a, coord_type b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      if (d > GAP_CLAMP) d = GAP_CLAMP;
      return d;
   endfunction

   function automatic longint unsigned sep_sq(input coord_type wx [5], input coord_type wy [5],
                                              input coord_type wz [5], int i, int j);
      longint unsigned dx, dy, dz;
      dx = axis_gap(wx[i], wx[j]);
      dy = axis_gap(wy[i], wy[j]);
      dz = axis_gap(wz[i], wz[j]);
      return dx * dx + dy * dy + dz * dz;
   endfunction

   // Strict band test in hundredths of an angstrom against squared units.
   function automatic bit in_band(longint unsigned d2, longint unsigned target,
                                  longint unsigned tol);
      longint unsigned s, lo, hi;
      s  = d2 * 64'd10000;
      lo = target - tol;
      hi = target + tol;
      return (s > lo * lo * 64'd65536) && (s < hi * hi * 64'd65536);
   endfunction

   function automatic ca_dss_pkg::ss_code_type classify_window(input coord_type wx [5],
                                                               input coord_type wy [5],
                                                               input coord_type wz [5]);
      longint unsigned d13, d14, d15, d24, d25, d35;
      d13 = sep_sq(wx, wy, wz, 0, 2);
      d14 = sep_sq(wx, wy, wz, 0, 3);
      d15 = sep_sq(wx, wy, wz, 0, 4);
      d24 = sep_sq(wx, wy, wz, 1, 3);
      d25 = sep_sq(wx, wy, wz, 1, 4);
      d35 = sep_sq(wx, wy, wz, 2, 4);
      if (in_band(d15, 637, 210) && in_band(d14, 518, 210) && in_band(d25, 518, 210) &&
          in_band(d13, 545, 210) && in_band(d24, 545, 210) && in_band(d35, 545, 210))
         return ca_dss_pkg::SS_HELIX;
      if (in_band(d15, 1300, 142) && in_band(d14, 1040, 142) && in_band(d25, 1040, 142) &&
          in_band(d13, 610, 142) && in_band(d24, 610, 142) && in_band(d35, 610, 142))
         return ca_dss_pkg::SS_STRAND;
      if (d15 * 64'd10000 < 64'd800 * 64'd800 * 64'd65536)
         return ca_dss_pkg::SS_TURN;
      return ca_dss_pkg::SS_LOOP;
   endfunction

   // Work out the words one accepted residue causes and advance the window.
   function automatic void predict_codes(coord_type x, coord_type y, coord_type z, logic last);
      ss_word_type words [3];
      coord_type   wx [5];
      coord_type   wy [5];
      coord_type   wz [5];
      int unsigned p;
      int          n;
      int          tail;
      p = residues_in_chain;
      n = 0;
      for (int k = 0; k < 3; k++)
         words[k] = '{code: ca_dss_pkg::SS_LOOP, run_last: 1'b0, chain_end: 1'b0};
      if (p < 2) begin
         n = 1;
      end else if (p >= 4) begin
         for (int k = 0; k < 4; k++) begin
            wx[k] = win_x[k];
            wy[k] = win_y[k];
            wz[k] = win_z[k];
         end
         wx[4] = x;
         wy[4] = y;
         wz[4] = z;
         words[0].code = classify_window(wx, wy, wz);
         n = 1;
      end
      // The chain end flushes the residues still held as loop.
      if (last) begin
         tail = (p < 2) ? 0 : ((p == 2) ? 1 : 2);
         n = n + tail;
      end
      if (n > 0) begin
         words[n-1].run_last = 1'b1;
         if (last) words[n-1].chain_end = 1'b1;
      end
      for (int k = 0; k < n; k++) expected_codes.push_back(words[k]);
      for (int k = 0; k < 3; k++) begin
         win_x[k] = win_x[k+1];
         win_y[k] = win_y[k+1];
         win_z[k] = win_z[k+1];
      end
      win_x[3] = x;
      win_y[3] = y;
      win_z[3] = z;
      if (last) residues_in_chain = 0;
      else if (p < 4) residues_in_chain = p + 1;
      else residues_in_chain = 4;
   endfunction

   function automatic void note_mismatch(string what);
      if (mismatches < MAX_SHOWN) $display("MISMATCH at cycle %0d: %s", cycles, what);
      mismatches++;
   endfunction

   // Offer one residue word, with a random gap first, and predict on acceptance.
   task automatic push_residue(coord_type x, coord_type y, coord_type z, logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.coord_x    <= x;
      req_bus.coord_y    <= y;
      req_bus.coord_z    <= z;
      req_bus.chain_last <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_codes(x, y, z, last);
      residues_sent++;
      if (last) chains_sent++;
   endtask

   // Hold the sender off until every predicted word has come out.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Chains of one to four residues: every start and end case without a full window.
   task automatic test_short_chains();
      idle_pct  = 0;
      stall_pct = 0;
      for (int len = 1; len <= 4; len++) begin
         for (int i = 0; i < len; i++)
            push_residue(coord_type'(973 * i), '0, '0, i == len - 1);
      end
      wait_drained();
   endtask

   // One window per shape, including distances exactly on the turn bound.
   task automatic test_shape_windows();
      int bound_x [6] = '{0, 0, 0, 0, 2048, 2047};
      idle_pct  = 0;
      stall_pct = 30;
      // Evenly spaced line at 2 angstrom lands inside every helix band.
      for (int i = 0; i < 5; i++)
         push_residue(coord_type'(512 * i), coord_type'(1000), '0, i == 4);
      // Zigzag at 3.3 angstrom rise is a strand.
      for (int i = 0; i < 5; i++)
         push_residue(coord_type'(845 * i), coord_type'((i % 2) ? 230 : -230),
                      coord_type'(-5000), i == 4);
      // Exactly 8 angstrom end to end is loop; one unit shorter is turn.
      for (int i = 0; i < 6; i++) push_residue(coord_type'(bound_x[i]), '0, '0, i == 5);
      wait_drained();
   endtask

   // Opposite corners of the coordinate range force clamped differences; the
   // chain is long enough for the residue count to saturate.
   task automatic test_extreme_coords();
      idle_pct  = 0;
      stall_pct = 0;
      for (int i = 0; i < 6; i++) begin
         if (i % 2)
            push_residue(coord_type'(C_MAX), coord_type'(C_MIN), coord_type'(C_MAX), i == 5);
         else
            push_residue(coord_type'(C_MIN), coord_type'(C_MAX), coord_type'(C_MIN), i == 5);
      end
      wait_drained();
   endtask

   // Sender stops in the middle of a helix until the block has gone quiet.
   task automatic test_pause_mid_chain();
      real ang;
      idle_pct  = 0;
      stall_pct = 50;
      for (int i = 0; i < 10; i++) begin
         ang = i * 100.0 * PI / 180.0;
         push_residue(coord_type'(int'(589.0 * $cos(ang))),
                      coord_type'(int'(589.0 * $sin(ang))),
                      coord_type'(384 * i), i == 9);
         if (i == 6) wait_drained();
      end
      wait_drained();
   endtask

   // Well-formed chains of mixed geometry with some noise words.
   task automatic test_random_phase(int idle, int stall, int goal);
      int  sent;
      int  len, style, jit;
      int  bx, by, bz, ox, oy, oz, wx, wy, wz;
      real ang;
      coord_type cx, cy, cz;
      idle_pct  = idle;
      stall_pct = stall;
      sent      = 0;
      while (sent < goal) begin
         len   = ($urandom_range(7) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 24);
         style = $urandom_range(5);
         jit   = $urandom_range(120);
         bx    = int'($urandom_range(4000000)) - 2000000;
         by    = int'($urandom_range(4000000)) - 2000000;
         bz    = int'($urandom_range(4000000)) - 2000000;
         wx    = 0;
         wy    = 0;
         wz    = 0;
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) style = $urandom_range(5);
            case (style)
               0: begin
                  ang = i * 100.0 * PI / 180.0;
                  ox  = int'(589.0 * $cos(ang));
                  oy  = int'(589.0 * $sin(ang));
                  oz  = 384 * i;
               end
               1: begin
                  ox = 845 * i;
                  oy = (i % 2) ? 230 : -230;
                  oz = 0;
               end
               2: begin
                  ox = int'($urandom_range(640)) - 320;
                  oy = int'($urandom_range(640)) - 320;
                  oz = int'($urandom_range(640)) - 320;
               end
               3: begin
                  ox = 973 * i;
                  oy = 0;
                  oz = 0;
               end
               default: begin
                  wx = wx + int'($urandom_range(1536)) - 768;
                  wy = wy + int'($urandom_range(1536)) - 768;
                  wz = wz + int'($urandom_range(1536)) - 768;
                  ox = wx;
                  oy = wy;
                  oz = wz;
               end
            endcase
            ox = ox + int'($urandom_range(2 * jit)) - jit;
            oy = oy + int'($urandom_range(2 * jit)) - jit;
            oz = oz + int'($urandom_range(2 * jit)) - jit;
            if (style == 5 || $urandom_range(39) == 0) begin
               cx = coord_type'($urandom);
               cy = coord_type'($urandom);
               cz = coord_type'($urandom);
            end else begin
               cx = coord_type'(bx + ox);
               cy = coord_type'(by + oy);
               cz = coord_type'(bz + oz);
            end
            push_residue(cx, cy, cz, i == len - 1);
            sent++;
         end
      end
      wait_drained();
   endtask

   // Receiver stalls at the current rate.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Compare every accepted classification word with the oldest prediction.
   always @(posedge clock) begin
      ss_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_codes.size() == 0) begin
            note_mismatch($sformatf("unexpected word code %0d run_last %0b chain_end %0b",
                                    rsp_bus.ss_code, rsp_bus.run_last, rsp_bus.chain_end));
         end else begin
            want = expected_codes.pop_front();
            code_count[want.code]++;
            if (rsp_bus.ss_code !== want.code || rsp_bus.run_last !== want.run_last ||
                rsp_bus.chain_end !== want.chain_end)
               note_mismatch($sformatf(
                  "expected code %0d run_last %0b chain_end %0b, got %0d %0b %0b",
                  want.code, want.run_last, want.chain_end,
                  rsp_bus.ss_code, rsp_bus.run_last, rsp_bus.chain_end));
         end
      end
   end

   // Watchdog on the cycle count.
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timed out after %0d cycles", cycles);
      $display("ca_distance_ss_classifier_tb NOT OK");
      $finish;
   end

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.coord_x    <= '0;
      req_bus.coord_y    <= '0;
      req_bus.coord_z    <= '0;
      req_bus.chain_last <= 1'b0;
      idle_pct           = 0;
      stall_pct          = 0;
      mismatches         = 0;
      residues_sent      = 0;
      chains_sent        = 0;
      residues_in_chain  = 0;
      for (int k = 0; k < 4; k++) code_count[k] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_chains();
      test_shape_windows();
      test_extreme_coords();
      test_pause_mid_chain();
      test_random_phase(0, 0, 100);
      test_random_phase(73, 0, 100);
      test_random_phase(0, 73, 100);
      test_random_phase(24, 24, 100);
      wait_drained();

      if (expected_codes.size() != 0)
         note_mismatch($sformatf("%0d words never arrived", expected_codes.size()));
      $display("Sent %0d residues in %0d chains; checked loop %0d, helix %0d,",
               residues_sent, chains_sent, code_count[ca_dss_pkg::SS_LOOP],
               code_count[ca_dss_pkg::SS_HELIX]);
      $display("strand %0d, turn %0d; traffic ran without gaps, with sender gaps, %s%0d %s",
               code_count[ca_dss_pkg::SS_STRAND], code_count[ca_dss_pkg::SS_TURN],
               "receiver stalls and both; ", mismatches, "mismatches.");
      if (mismatches == 0) begin
         $display("ca_distance_ss_classifier_tb OK");
      end else begin
         $display("ca_distance_ss_classifier_tb NOT OK");
      end
      $finish;
   end

endmodule
